// ===== rtl/url_text_sanitize_decode_unit_assert.svh =====
// Assertion macros for the checker file of the URL text decoder.
`ifndef URL_TEXT_SANITIZE_DECODE_UNIT_ASSERT_SVH
`define URL_TEXT_SANITIZE_DECODE_UNIT_ASSERT_SVH

// Property checked at every rising clock edge outside reset.
`define UTSD_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen at a rising clock edge outside reset.
`define UTSD_NEVER(label, clk, rst_n, cond, msg) \
	`UTSD_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

// ===== rtl/utsd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utsd_pkg
// Types, character codes and hex helpers for the URL text sanitizing decoder.
// ----------------------------------------------------------------------------
package utsd_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       out_last;
	} out_item_t;

	typedef logic [1:0] esc_phase_t;

	localparam esc_phase_t PH_IDLE    = 2'd0;
	localparam esc_phase_t PH_PERCENT = 2'd1;
	localparam esc_phase_t PH_DIGIT   = 2'd2;

	localparam logic [7:0] CHR_PERCENT = 8'h25;
	localparam logic [7:0] CHR_PLUS    = 8'h2B;
	localparam logic [7:0] CHR_SEMI    = 8'h3B;
	localparam logic [7:0] CHR_SPACE   = 8'h20;
	localparam logic [7:0] CHR_BANG    = 8'h21;
	localparam logic [7:0] CHR_TILDE   = 8'h7E;
	localparam logic [7:0] CHR_NUL     = 8'h00;
	localparam logic [7:0] CHR_0       = 8'h30;
	localparam logic [7:0] CHR_9       = 8'h39;
	localparam logic [7:0] CHR_UA      = 8'h41;
	localparam logic [7:0] CHR_UF      = 8'h46;
	localparam logic [7:0] CHR_LA      = 8'h61;
	localparam logic [7:0] CHR_LF      = 8'h66;

	// Number of result slots one item can produce.
	localparam int unsigned MAX_RES = 3;

	function automatic logic is_hex(input logic [7:0] c);
		return ((c >= CHR_0) && (c <= CHR_9)) || ((c >= CHR_LA) && (c <= CHR_LF)) ||
			((c >= CHR_UA) && (c <= CHR_UF));
	endfunction

	// Digit value of a hex character; only called on characters that pass is_hex.
	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] v;
		if (c >= CHR_LA) begin
			v = c - CHR_LA + 8'd10;
		end else if (c >= CHR_UA) begin
			v = c - CHR_UA + 8'd10;
		end else begin
			v = c - CHR_0;
		end
		return v[3:0];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/url_text_sanitize_decode_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// url_text_sanitize_decode_unit
// Filters a terminated byte stream to printable characters and percent-decodes it.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one raw byte per item with
//   a last flag. Output channel (out_valid/out_ready/out_data) gives decoded
//   bytes; the final result of a string has out_last set, and when nothing is
//   left to emit it is a bare end mark with has_byte low.
//   An accepted item is registered, decoded combinationally and, once the
//   three-entry result buffer is free, written to it; its results show on
//   out_valid from the buffer, and an item may yield no result at all.
//   Throughput is one item per cycle while out_ready is high and each item
//   yields at most one result. An item yielding several results (broken or
//   trailing escapes) occupies the result buffer until it drains, one result
//   per cycle while out_ready is high, and the input stalls meanwhile.
//   When out_ready is low, the buffer holds its results and the input register
//   still takes one more item before in_ready drops.
//   Reset empties the input register and the result buffer and clears the
//   escape and truncation state; the block is ready once reset is released.
// ----------------------------------------------------------------------------
module url_text_sanitize_decode_unit
	import utsd_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_data
);

	logic       valid_s1;
	in_item_t   data_s1;
	esc_phase_t phase_q;
	logic [7:0] held_q;
	logic       trunc_q;
	out_item_t  buf_q [MAX_RES];
	logic [1:0] rd_q;
	logic [1:0] rem_q;

	logic       buf_free;
	logic       consume;

	logic [7:0] c;
	logic       keep;
	logic       hex;
	logic       broken;
	logic       run_idle;
	esc_phase_t ph_d;
	logic [7:0] held_d;
	logic [7:0] slot_byte [5];
	logic [4:0] slot_vld;
	logic       trunc_d;
	logic [1:0] cnt;
	out_item_t  res [MAX_RES];

	assign buf_free = (rem_q == 2'd0) || ((rem_q == 2'd1) && out_ready);
	assign consume  = valid_s1 && buf_free;
	assign in_ready = !valid_s1 || buf_free;

	assign out_valid = (rem_q != 2'd0);
	assign out_data  = buf_q[rd_q];

	// Decode of the registered item: build up to five candidate emits in stream
	// order, then drop them through the zero-byte truncation.
	always_comb begin
		c        = data_s1.in_byte;
		keep     = (c >= CHR_BANG) && (c <= CHR_TILDE) && (c != CHR_SEMI);
		hex      = is_hex(c);
		broken   = keep && !hex && ((phase_q == PH_PERCENT) || (phase_q == PH_DIGIT));
		run_idle = keep && (broken || ((phase_q != PH_PERCENT) && (phase_q != PH_DIGIT)));

		ph_d   = phase_q;
		held_d = held_q;
		if (keep && hex && (phase_q == PH_PERCENT)) begin
			ph_d   = PH_DIGIT;
			held_d = c;
		end else if (keep && hex && (phase_q == PH_DIGIT)) begin
			ph_d = PH_IDLE;
		end else if (run_idle) begin
			ph_d = (c == CHR_PERCENT) ? PH_PERCENT : PH_IDLE;
		end

		slot_byte[0] = CHR_PERCENT;
		slot_vld[0]  = broken;
		slot_byte[1] = held_q;
		slot_vld[1]  = broken && (phase_q == PH_DIGIT);
		if (keep && hex && (phase_q == PH_DIGIT)) begin
			slot_byte[2] = {hex_val(held_q), hex_val(c)};
			slot_vld[2]  = 1'b1;
		end else begin
			slot_byte[2] = (c == CHR_PLUS) ? CHR_SPACE : c;
			slot_vld[2]  = run_idle && (c != CHR_PERCENT);
		end
		// A pending escape at end of string passes through literally.
		slot_byte[3] = CHR_PERCENT;
		slot_vld[3]  = data_s1.in_last && ((ph_d == PH_PERCENT) || (ph_d == PH_DIGIT));
		slot_byte[4] = held_d;
		slot_vld[4]  = data_s1.in_last && (ph_d == PH_DIGIT);

		trunc_d = trunc_q;
		cnt     = 2'd0;
		for (int i = 0; i < MAX_RES; i++) begin
			res[i] = '0;
		end
		for (int i = 0; i < 5; i++) begin
			if (slot_vld[i] && !trunc_d) begin
				if (slot_byte[i] == CHR_NUL) begin
					trunc_d = 1'b1;
				end else if (cnt != 2'd3) begin
					res[cnt].out_byte = slot_byte[i];
					res[cnt].has_byte = 1'b1;
					cnt = cnt + 2'd1;
				end
			end
		end

		if (data_s1.in_last) begin
			if (cnt == 2'd0) begin
				res[0].out_last = 1'b1;
				cnt = 2'd1;
			end else begin
				for (int i = 0; i < MAX_RES; i++) begin
					if (2'(i) == (cnt - 2'd1)) begin
						res[i].out_last = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			held_q  <= CHR_NUL;
			trunc_q <= 1'b0;
		end else if (consume) begin
			if (data_s1.in_last) begin
				phase_q <= PH_IDLE;
				held_q  <= CHR_NUL;
				trunc_q <= 1'b0;
			end else begin
				phase_q <= ph_d;
				held_q  <= held_d;
				trunc_q <= trunc_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 2'd0;
			rem_q <= 2'd0;
		end else if (consume) begin
			rd_q  <= 2'd0;
			rem_q <= cnt;
		end else if (out_valid && out_ready) begin
			rd_q  <= rd_q + 2'd1;
			rem_q <= rem_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (consume) begin
			for (int i = 0; i < MAX_RES; i++) begin
				buf_q[i] <= res[i];
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/utsd_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utsd_checker
// Port-level checks on the URL text sanitizing decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "url_text_sanitize_decode_unit_assert.svh"

module utsd_checker
	import utsd_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_valid,
	input wire logic      in_ready,
	input wire in_item_t  in_data,
	input wire logic      out_valid,
	input wire logic      out_ready,
	input wire out_item_t out_data
);

	// A waiting input item must stay on the port unchanged until it is taken.
	`UTSD_ASSERT(a_in_hold, clk, arst_n, (in_valid && !in_ready) |=> (in_valid && $stable(in_data)), "waiting input item changed or dropped")

	// A stalled result must stay on the port unchanged.
	`UTSD_ASSERT(a_out_hold, clk, arst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_data)), "stalled output item changed or dropped")

	// An item without a character only ever appears as the end mark.
	`UTSD_NEVER(a_bare_is_last, clk, arst_n, out_valid && !out_data.has_byte && !out_data.out_last, "bare item without end mark")

	// A bare end mark carries a zero byte.
	`UTSD_NEVER(a_bare_zero, clk, arst_n, out_valid && !out_data.has_byte && (out_data.out_byte != 8'h00), "bare end mark with nonzero byte")

	// Decoded zero bytes truncate the string and are never delivered.
	`UTSD_NEVER(a_no_nul, clk, arst_n, out_valid && out_data.has_byte && (out_data.out_byte == 8'h00), "zero byte delivered as character")

endmodule

bind url_text_sanitize_decode_unit utsd_checker u_utsd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
`default_nettype wire
